/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/jdz_pkg.sv */
`default_nettype none
package jdz_pkg;
  localparam int SampleBits = 16;
  localparam int FracBits = 15;
  localparam int OutBits = FracBits + 1;
  localparam int SqBits = 2 * SampleBits;
  localparam int RootBits = SampleBits;
  // Divider widths: numerator up to (2^SampleBits) << FracBits plus margin.
  localparam int NumBits = SampleBits + FracBits + 2;
  localparam int DenBits = SampleBits + 1;
  localparam logic [FracBits:0] OneQ = {1'b1, {FracBits{1'b0}}};
  localparam logic [FracBits:0] MaxQ = {1'b0, {FracBits{1'b1}}};

  localparam logic [1:0] RegAxisDz = 2'd0;
  localparam logic [1:0] RegAxisFs = 2'd1;
  localparam logic [1:0] RegStickDz = 2'd2;
  localparam logic [1:0] RegStickFs = 2'd3;

  typedef struct packed {
    logic                  stick;
    logic                  dead;
    logic                  nx;
    logic                  ny;
    logic [SampleBits-1:0] ax;
    logic [SampleBits-1:0] ay;
    logic [SqBits:0]       sq;
  } job_t;

  typedef struct packed {
    logic [OutBits-1:0] x;
    logic [OutBits-1:0] y;
    logic               dead;
  } res_t;
endpackage
`default_nettype wire

/* rtl/jdz_front.sv */
`default_nettype none
// Front end: magnitudes, squared length and dead-zone classification.
module jdz_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic req_type_i,
  input  wire logic [jdz_pkg::SampleBits-1:0] raw_x_i,
  input  wire logic [jdz_pkg::SampleBits-1:0] raw_y_i,
  input  wire logic [14:0] axis_dz_i,
  input  wire logic [15:0] stick_dz_i,
  output logic      job_valid_o,
  input  wire logic job_ready_i,
  output jdz_pkg::job_t job_o
);
  import jdz_pkg::*;
  // Two stages: magnitudes + squares, then sum + compare.
  logic v1_q, v2_q;
  logic st1_q, nx1_q, ny1_q;
  logic [SampleBits-1:0] ax1_q, ay1_q;
  logic [SqBits-1:0] sx1_q, sy1_q;
  job_t j2_q;
  logic adv2, adv1;
  logic [SampleBits-1:0] ax_c, ay_c;
  logic [SqBits:0] s_c;
  logic [SqBits-1:0] dzsq_c;

  assign adv2 = !v2_q || job_ready_i;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign ax_c = raw_x_i[SampleBits-1] ? SampleBits'(-raw_x_i) : raw_x_i;
  assign ay_c = raw_y_i[SampleBits-1] ? SampleBits'(-raw_y_i) : raw_y_i;
  assign s_c = (SqBits+1)'(sx1_q) + (SqBits+1)'(sy1_q);
  assign dzsq_c = stick_dz_i * stick_dz_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      st1_q <= req_type_i;
      nx1_q <= raw_x_i[SampleBits-1];
      ny1_q <= raw_y_i[SampleBits-1];
      ax1_q <= ax_c;
      ay1_q <= ay_c;
      sx1_q <= ax_c * ax_c;
      sy1_q <= ay_c * ay_c;
    end
    if (adv2 && v1_q) begin
      j2_q.stick <= st1_q;
      j2_q.nx <= nx1_q;
      j2_q.ny <= ny1_q;
      j2_q.ax <= ax1_q;
      j2_q.ay <= ay1_q;
      j2_q.sq <= s_c;
      j2_q.dead <= st1_q ? (s_c < (SqBits+1)'(dzsq_c))
                         : ({1'b0, ax1_q} <= (SampleBits+1)'(axis_dz_i));
    end
  end

  assign job_valid_o = v2_q;
  assign job_o = j2_q;
endmodule
`default_nettype wire

/* rtl/jdz_queue.sv */
`default_nettype none
// Two-entry queue between front and back.
module jdz_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  input  jdz_pkg::job_t wr_data_i,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i,
  output jdz_pkg::job_t rd_data_o
);
  import jdz_pkg::*;
  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;
  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

/* rtl/jdz_div.sv */
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, NumBits stages.
module jdz_div (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic [jdz_pkg::NumBits-1:0] num_i,
  input  wire logic [jdz_pkg::DenBits-1:0] den_i,
  input  jdz_pkg::res_t tag_i,
  output logic [jdz_pkg::NumBits-1:0] quo_o,
  output jdz_pkg::res_t tag_o
);
  import jdz_pkg::*;
  localparam int RemBits = DenBits + 1;
  logic [NumBits-1:0] n_q [NumBits+1];
  logic [NumBits-1:0] q_q [NumBits+1];
  logic [RemBits-1:0] r_q [NumBits+1];
  logic [DenBits-1:0] d_q [NumBits+1];
  res_t t_q [NumBits+1];

  assign n_q[0] = num_i;
  assign q_q[0] = '0;
  assign r_q[0] = '0;
  assign d_q[0] = den_i;
  assign t_q[0] = tag_i;

  for (genvar s = 0; s < NumBits; s++) begin : g_st
    logic [RemBits-1:0] tr;
    logic ge;
    assign tr = {r_q[s][RemBits-2:0], n_q[s][NumBits-1]};
    assign ge = tr >= {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1] <= {n_q[s][NumBits-2:0], 1'b0};
        q_q[s+1] <= {q_q[s][NumBits-2:0], ge};
        r_q[s+1] <= ge ? tr - {1'b0, d_q[s]} : tr;
        d_q[s+1] <= d_q[s];
        t_q[s+1] <= t_q[s];
      end
    end
  end
  assign quo_o = q_q[NumBits];
  assign tag_o = t_q[NumBits];
  logic unused;
  assign unused = rst_ni;
endmodule
`default_nettype wire

/* rtl/jdz_sqrt.sv */
`default_nettype none
// Pipelined integer square root, one root bit per stage.
module jdz_sqrt (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire logic [jdz_pkg::SqBits:0] rad_i,
  input  jdz_pkg::job_t job_i,
  output logic [jdz_pkg::RootBits:0] root_o,
  output jdz_pkg::job_t job_o
);
  import jdz_pkg::*;
  localparam int Steps = RootBits + 1;
  localparam int RadBits = 2 * Steps;
  logic [RadBits-1:0] n_q [Steps+1];
  logic [Steps-1:0] rt_q [Steps+1];
  logic [Steps+1:0] rm_q [Steps+1];
  job_t j_q [Steps+1];
  assign n_q[0] = RadBits'(rad_i);
  assign rt_q[0] = '0;
  assign rm_q[0] = '0;
  assign j_q[0] = job_i;
  for (genvar s = 0; s < Steps; s++) begin : g_st
    logic [Steps+1:0] tr, tst;
    logic ge;
    assign tr = {rm_q[s][Steps-1:0], n_q[s][RadBits-1 -: 2]};
    assign tst = {rt_q[s], 2'b01};
    assign ge = tr >= tst;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1] <= {n_q[s][RadBits-3:0], 2'b00};
        rt_q[s+1] <= {rt_q[s][Steps-2:0], ge};
        rm_q[s+1] <= ge ? tr - tst : tr;
        j_q[s+1] <= j_q[s];
      end
    end
  end
  assign root_o = rt_q[Steps];
  assign job_o = j_q[Steps];
endmodule
`default_nettype wire

/* rtl/jdz_back.sv */
`default_nettype none
// Back end: a stall-as-one pipeline of root, fraction divide, two component
// divides and saturation. A skid buffer at the end gives full rate.
module jdz_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  jdz_pkg::job_t job_i,
  input  wire logic [14:0] axis_dz_i,
  input  wire logic [15:0] axis_fs_i,
  input  wire logic [15:0] stick_dz_i,
  input  wire logic [15:0] stick_fs_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output jdz_pkg::res_t res_o
);
  import jdz_pkg::*;
  localparam int SqSt = RootBits + 1;
  localparam int Depth = SqSt + 1 + NumBits + 1 + NumBits;
  logic [Depth-1:0] v_q;
  logic en;
  logic [RootBits:0] root;
  job_t js;
  // Skid: two output slots.
  res_t o_q [2];
  logic [1:0] oc_q;
  logic orp_q, owp_q;
  logic out_w, out_r;

  // Stall the whole pipe when output is full and the last stage holds an item.
  assign en = !(v_q[Depth-1] && oc_q == 2'd2);
  assign job_ready_o = en;

  jdz_sqrt u_sqrt (.clk_i, .en_i(en), .rad_i(job_i.sq), .job_i(job_i),
                   .root_o(root), .job_o(js));

  // Stage A: fraction numerator/denominator.
  res_t tag_a;
  logic [NumBits-1:0] num_a_d, num_a_q;
  logic [DenBits-1:0] den_a_d, den_a_q;
  job_t ja_q;
  logic [RootBits:0] len_a_q;
  logic byp_a_d, byp_a_q;
  always_comb begin
    num_a_d = '0;
    den_a_d = DenBits'(1);
    byp_a_d = 1'b0;
    if (js.stick) begin
      if (stick_fs_i > stick_dz_i) begin
        num_a_d = NumBits'((root - (RootBits+1)'(stick_dz_i))) << FracBits;
        den_a_d = DenBits'(stick_fs_i - stick_dz_i);
      end else byp_a_d = 1'b1;
    end else begin
      if (axis_fs_i > {1'b0, axis_dz_i}) begin
        num_a_d = NumBits'(js.ax - {1'b0, axis_dz_i}) << FracBits;
        den_a_d = DenBits'(axis_fs_i - {1'b0, axis_dz_i});
      end else byp_a_d = 1'b1;
    end
  end
  assign tag_a = '0;
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_a_q <= num_a_d;
      den_a_q <= den_a_d;
      ja_q <= js;
      len_a_q <= root;
      byp_a_q <= byp_a_d;
    end
  end
  logic [NumBits-1:0] fq;
  res_t unused_t1, unused_t2;
  jdz_div u_fdiv (.clk_i, .rst_ni, .en_i(en), .num_i(num_a_q), .den_i(den_a_q),
                  .tag_i(tag_a), .quo_o(fq), .tag_o(unused_t1));
  // Delay job info along the divider.
  job_t jd_q [NumBits+1];
  logic [RootBits:0] ld_q [NumBits+1];
  logic bd_q [NumBits+1];
  assign jd_q[0] = ja_q;
  assign ld_q[0] = len_a_q;
  assign bd_q[0] = byp_a_q;
  for (genvar s = 0; s < NumBits; s++) begin : g_dl
    always_ff @(posedge clk_i) begin
      if (en) begin
        jd_q[s+1] <= jd_q[s];
        ld_q[s+1] <= ld_q[s];
        bd_q[s+1] <= bd_q[s];
      end
    end
  end
  job_t jb;
  logic [RootBits:0] lb;
  logic [FracBits:0] f_c;
  assign jb = jd_q[NumBits];
  assign lb = ld_q[NumBits];
  always_comb begin
    if (jb.stick) f_c = (bd_q[NumBits] || fq > NumBits'(OneQ)) ? OneQ : (FracBits+1)'(fq);
    else f_c = (bd_q[NumBits] || fq > NumBits'(MaxQ)) ? MaxQ : (FracBits+1)'(fq);
  end
  // Stage B: component products. A single axis passes its fraction through
  // the divider unchanged by dividing by one.
  logic [NumBits-1:0] px_q, py_q;
  logic [DenBits-1:0] dl_q;
  res_t tb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= jb.stick ? NumBits'(jb.ax * f_c) : NumBits'(f_c);
      py_q <= NumBits'(jb.ay * f_c);
      dl_q <= (lb == '0 || !jb.stick) ? DenBits'(1) : DenBits'(lb);
      tb_q.dead <= jb.dead;
      tb_q.x <= '0;
      tb_q.y <= {jb.ny, jb.stick, (OutBits-2)'(lb == '0)};
    end
  end
  logic [NumBits-1:0] qx, qy;
  res_t tx, ty;
  jdz_div u_xdiv (.clk_i, .rst_ni, .en_i(en), .num_i(px_q), .den_i(dl_q),
                  .tag_i(tb_q), .quo_o(qx), .tag_o(tx));
  jdz_div u_ydiv (.clk_i, .rst_ni, .en_i(en), .num_i(py_q), .den_i(dl_q),
                  .tag_i(tb_q), .quo_o(qy), .tag_o(ty));
  // Sign of x is carried in its own delay line.
  logic nxd;
  logic nx_q [NumBits+1];
  always_ff @(posedge clk_i) if (en) nx_q[0] <= jb.nx;
  for (genvar s = 0; s < NumBits; s++) begin : g_nx
    always_ff @(posedge clk_i) if (en) nx_q[s+1] <= nx_q[s];
  end
  assign nxd = nx_q[NumBits];
  // tb_q.y carries: [OutBits-1]=ny, [OutBits-2]=stick, [0]=zero length.
  logic sny, sst, szl;
  logic [FracBits:0] mx, my;
  res_t r_d;
  assign sny = tx.y[OutBits-1];
  assign sst = tx.y[OutBits-2];
  assign szl = tx.y[0];
  always_comb begin
    mx = (qx > NumBits'(MaxQ)) ? MaxQ : (FracBits+1)'(qx);
    my = (qy > NumBits'(MaxQ)) ? MaxQ : (FracBits+1)'(qy);
    r_d.dead = tx.dead;
    r_d.x = nxd ? OutBits'(-mx) : OutBits'(mx);
    r_d.y = sny ? OutBits'(-my) : OutBits'(my);
    if (!sst) r_d.y = '0;
    if (tx.dead || (sst && szl)) begin
      r_d.x = '0;
      r_d.y = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[Depth-2:0], job_valid_i};
  end

  assign out_w = en && v_q[Depth-1];
  assign out_r = res_valid_o && res_ready_i;
  assign res_valid_o = oc_q != 2'd0;
  assign res_o = o_q[orp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q <= '0;
      orp_q <= 1'b0;
      owp_q <= 1'b0;
    end else begin
      if (out_w) owp_q <= !owp_q;
      if (out_r) orp_q <= !orp_q;
      oc_q <= oc_q + 2'(out_w) - 2'(out_r);
    end
  end
  always_ff @(posedge clk_i) if (out_w) o_q[owp_q] <= r_d;
  assign unused_t2 = ty;
  logic unused;
  assign unused = ^{unused_t1, unused_t2, tx.x};
endmodule
`default_nettype wire

/* rtl/joystick_deadzone_scaler_top.sv */
// Dead-zone conditioning of controller axis and stick samples.
// Input beats arrive on s_axis (tuser = req_type, tdata = raw_x then raw_y),
// results leave on m_axis (tdata = out_x then out_y, tuser = in_dead_zone).
// Registers are written on the cfg channel (index 0..3); write them only while idle (not enforced by the block).
// One beat is accepted every cycle while s_axis_tready is high; results leave in order.
// After its input beat is accepted, a result passes through the
// second front stage, the queue, 17 root stages, a fraction register,
// 33 divider stages, a product register, 33 more divider stages and the
// output buffer. The pipelined square root and dividers set the length.
// When m_axis stalls, a two-slot output buffer and a two-entry queue
// absorb beats, then s_axis_tready drops; nothing is lost.
// Reset clears all pipelines and loads the default register values.
`default_nettype none
module joystick_deadzone_scaler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // raw_x[15:0], raw_y[31:16]
  input  wire logic        s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // out_x[15:0], out_y[31:16]
  output logic             m_axis_tuser,  // in_dead_zone
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import jdz_pkg::*;
  logic [14:0] axis_dz_q;
  logic [15:0] axis_fs_q, stick_dz_q, stick_fs_q;
  job_t fj, qj;
  logic fv, fr, qv, qr;
  res_t r;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_dz_q <= 15'd250;
      axis_fs_q <= 16'd30000;
      stick_dz_q <= 16'd8000;
      stick_fs_q <= 16'd30000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAxisDz: axis_dz_q <= cfg_data_i[14:0];
        RegAxisFs: axis_fs_q <= cfg_data_i;
        RegStickDz: stick_dz_q <= cfg_data_i;
        RegStickFs: stick_fs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  jdz_front u_front (.clk_i, .rst_ni, .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready), .req_type_i(s_axis_tuser),
    .raw_x_i(s_axis_tdata[15:0]), .raw_y_i(s_axis_tdata[31:16]),
    .axis_dz_i(axis_dz_q), .stick_dz_i(stick_dz_q),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj));
  jdz_queue u_queue (.clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr),
    .wr_data_i(fj), .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qj));
  jdz_back u_back (.clk_i, .rst_ni, .job_valid_i(qv), .job_ready_o(qr),
    .job_i(qj), .axis_dz_i(axis_dz_q), .axis_fs_i(axis_fs_q),
    .stick_dz_i(stick_dz_q), .stick_fs_i(stick_fs_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(r));
  assign m_axis_tdata = {r.y, r.x};
  assign m_axis_tuser = r.dead;
endmodule
`default_nettype wire

/* rtl/jdz_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module jdz_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  `ASSERT_IMP(a_dead_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)
  `ASSERT_IMP(a_no_minx, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:0] != 16'h8000)
  `ASSERT_IMP(a_no_miny, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:16] != 16'h8000)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
bind joystick_deadzone_scaler_top jdz_checker u_chk (.*);
`default_nettype wire
